// File: hdl/ahfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfp_pkg
// Shared types and byte codes for the address-header frame parser.
// ----------------------------------------------------------------------------
package ahfp_pkg;

  // Characters and digit bounds (bounds are exclusive).
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] DIG_LO_EXC = 8'd47;
  localparam logic [7:0] ADDR_HI_EXC = 8'd53;
  localparam logic [7:0] TYPE_HI_EXC = 8'd58;
  localparam logic [7:0] DATA_HI_EXC = 8'd71;

  // Parser phases; code 7 is unused and treated as hunting.
  typedef enum logic [2:0] {
    PH_HUNT_A  = 3'd0,
    PH_WANT_D1 = 3'd1,
    PH_WANT_D2 = 3'd2,
    PH_WANT_R  = 3'd3,
    PH_ADDR    = 3'd4,
    PH_TYPE    = 3'd5,
    PH_DATA    = 3'd6
  } ph_t;

  // Emitter states.
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FETCH = 2'd1,
    BK_SHOW  = 2'd2
  } bk_state_t;

  // Per-frame header fields handed from parser to emitter.
  typedef struct packed {
    logic [2:0] addr;
    logic [3:0] ftype;
    logic       ovf;
  } hdr_t;

endpackage

// File: hdl/ahfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfp_front
// Byte parser: hunts for the header, takes the digits, writes data
// characters into the element memory and queues a frame descriptor on
// each line feed that ends a frame.
// ----------------------------------------------------------------------------
module ahfp_front #(
  parameter int DATA_DEPTH = 16,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4,
  parameter int Q_W        = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               q_full,
  output logic               q_push,
  output logic [Q_W-1:0]     q_wdata,
  output logic               wr_en,
  output logic [IDX_W:0]     wr_addr,
  output logic [4:0]         wr_data
);
  import ahfp_pkg::*;

  ph_t              phase_r, phase_nxt;
  logic [2:0]       addr_r, addr_nxt;
  logic [3:0]       type_r, type_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic             acc;
  logic             is_addr_dig, is_type_dig, is_data_ch, is_lf;
  hdr_t             hdr;

  assign in_stall    = q_full;
  assign acc         = in_valid && !in_stall;
  assign is_addr_dig = (in_rx_byte > DIG_LO_EXC) && (in_rx_byte < ADDR_HI_EXC);
  assign is_type_dig = (in_rx_byte > DIG_LO_EXC) && (in_rx_byte < TYPE_HI_EXC);
  assign is_data_ch  = (in_rx_byte > DIG_LO_EXC) && (in_rx_byte < DATA_HI_EXC);
  assign is_lf       = (in_rx_byte == CH_LF);

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_WANT_D1: phase_nxt = (in_rx_byte == CH_D) ? PH_WANT_D2 : PH_HUNT_A;
        PH_WANT_D2: phase_nxt = (in_rx_byte == CH_D) ? PH_WANT_R : PH_HUNT_A;
        PH_WANT_R:  phase_nxt = (in_rx_byte == CH_R) ? PH_ADDR : PH_HUNT_A;
        PH_ADDR:    phase_nxt = is_addr_dig ? PH_TYPE : PH_HUNT_A;
        PH_TYPE:    phase_nxt = is_type_dig ? PH_DATA : PH_HUNT_A;
        PH_DATA:    phase_nxt = (!is_lf && is_data_ch) ? PH_DATA : PH_HUNT_A;
        default:    phase_nxt = (in_rx_byte == CH_A) ? PH_WANT_D1 : PH_HUNT_A;
      endcase
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    type_nxt = type_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    q_push   = 1'b0;
    wr_en    = 1'b0;
    if (acc) begin
      unique case (phase_r)
        PH_ADDR: begin
          if (is_addr_dig) addr_nxt = 3'(in_rx_byte - CH_ZERO);
        end
        PH_TYPE: begin
          if (is_type_dig) begin
            type_nxt = 4'(in_rx_byte - CH_ZERO);
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
          end
        end
        PH_DATA: begin
          if (is_lf) begin
            // hand the frame to the emitter and switch to the other bank
            q_push   = 1'b1;
            bank_nxt = !bank_r;
          end else if (is_data_ch) begin
            if (cnt_r < CNT_W'(DATA_DEPTH)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign hdr.addr  = addr_r;
  assign hdr.ftype = type_r;
  assign hdr.ovf   = ovf_r;
  assign q_wdata   = {hdr, cnt_r, bank_r};
  assign wr_addr   = {bank_r, cnt_r[IDX_W-1:0]};
  assign wr_data   = 5'(in_rx_byte - CH_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_A;
      addr_r  <= '0;
      type_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// File: hdl/ahfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfp_queue
// Two-entry descriptor queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module ahfp_queue #(
  parameter int W = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);
  import ahfp_pkg::*;

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign rdata = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/ahfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfp_back
// Emitter: holds the two-bank element memory, plays out the frame at the
// queue head, one result per stored element or one empty result, and pops
// the descriptor once its last result is taken.
// ----------------------------------------------------------------------------
module ahfp_back #(
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4,
  parameter int Q_W        = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [IDX_W:0] wr_addr,
  input  logic [4:0]     wr_data,
  input  logic           q_empty,
  input  logic [Q_W-1:0] q_rdata,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_frame_addr,
  output logic [3:0]     out_frame_type,
  output logic [4:0]     out_data_count,
  output logic [3:0]     out_elem_index,
  output logic [4:0]     out_elem_value,
  output logic           out_elem_valid,
  output logic           out_overflowed,
  output logic           out_last
);
  import ahfp_pkg::*;

  localparam int MEM_D = 2 << IDX_W;

  logic [4:0]       elem_mem [MEM_D];
  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [4:0]       rd_data_r;
  hdr_t             hdr;
  logic [CNT_W-1:0] cnt;
  logic             bank;
  logic             empty_frame;
  logic             last;
  logic             rd_en;
  logic             advance;

  // the descriptor stays at the queue head, and its bank stays reserved,
  // until the final result of the frame is taken
  assign bank        = q_rdata[0];
  assign cnt         = q_rdata[CNT_W:1];
  assign hdr         = hdr_t'(q_rdata[Q_W-1:CNT_W+1]);
  assign empty_frame = (cnt == '0);
  assign last        = empty_frame || ((idx_r + CNT_W'(1)) == cnt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = BK_FETCH;
      BK_FETCH: state_nxt = BK_SHOW;
      BK_SHOW:  if (!out_stall) state_nxt = last ? BK_IDLE : BK_FETCH;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    advance   = 1'b0;
    unique case (state_r)
      BK_FETCH: rd_en = 1'b1;
      BK_SHOW: begin
        out_valid = 1'b1;
        advance   = !out_stall && !last;
        q_pop     = !out_stall && last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) elem_mem[wr_addr] <= wr_data;
  end

  // read data doubles as the output register for the element value
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= elem_mem[{bank, idx_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE) idx_r <= '0;
      else if (advance)       idx_r <= idx_r + CNT_W'(1);
    end
  end

  assign out_frame_addr = hdr.addr;
  assign out_frame_type = hdr.ftype;
  assign out_data_count = 5'(cnt);
  assign out_elem_index = 4'(idx_r);
  assign out_elem_value = empty_frame ? 5'd0 : rd_data_r;
  assign out_elem_valid = !empty_frame;
  assign out_overflowed = hdr.ovf;
  assign out_last       = last;

endmodule

// File: hdl/addr_header_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addr_header_frame_parser
// Parses "ADDR<addr><type><data...>LF" frames from a byte stream and plays
// out the stored data elements, one result per element.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle and needs no time of its own per byte;
// it stalls the input only while two finished frames are outstanding, the
// one being played out included, since each of them holds a memory bank.
// Data characters go into one bank of a two-bank element memory while the
// other bank is being emitted. On a line feed a frame descriptor enters a
// two-entry queue; the emitter picks it up and makes each result by a
// registered memory read followed by showing the result, which is held
// while out_stall is high. Characters past DATA_DEPTH are dropped and
// flagged on every result of the frame. data_count and elem_index carry the
// low 5 and 4 bits of their values.
module addr_header_frame_parser #(
  parameter int DATA_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_frame_addr,
  output logic [3:0] out_frame_type,
  output logic [4:0] out_data_count,
  output logic [3:0] out_elem_index,
  output logic [4:0] out_elem_value,
  output logic       out_elem_valid,
  output logic       out_overflowed,
  output logic       out_last
);
  import ahfp_pkg::*;

  localparam int CNT_W = $clog2(DATA_DEPTH + 1);
  localparam int IDX_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int Q_W   = $bits(hdr_t) + CNT_W + 1;

  logic           q_full, q_empty, q_push, q_pop;
  logic [Q_W-1:0] q_wdata, q_rdata;
  logic           wr_en;
  logic [IDX_W:0] wr_addr;
  logic [4:0]     wr_data;

  ahfp_front #(
    .DATA_DEPTH (DATA_DEPTH),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W),
    .Q_W        (Q_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ahfp_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  ahfp_back #(
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W),
    .Q_W        (Q_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_addr (out_frame_addr),
    .out_frame_type (out_frame_type),
    .out_data_count (out_data_count),
    .out_elem_index (out_elem_index),
    .out_elem_value (out_elem_value),
    .out_elem_valid (out_elem_valid),
    .out_overflowed (out_overflowed),
    .out_last       (out_last)
  );

endmodule

// File: hdl/ahfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module ahfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_frame_addr,
  input logic [3:0] out_frame_type,
  input logic [4:0] out_data_count,
  input logic [3:0] out_elem_index,
  input logic [4:0] out_elem_value,
  input logic       out_elem_valid,
  input logic       out_overflowed,
  input logic       out_last
);
  import ahfp_pkg::*;

  // hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_elem_index)
      && $stable(out_elem_value) && $stable(out_last) && $stable(out_frame_addr))
    else $error("stalled result changed");

  // empty frame: single, zeroed result
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_elem_valid |-> out_last && out_data_count == 5'd0
      && out_elem_index == 4'd0 && out_elem_value == 5'd0 && !out_overflowed)
    else $error("malformed empty-frame result");

  // advance index within a frame, keep frame fields
  a_next_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> !out_valid ##1
      (out_valid && out_elem_valid
       && out_elem_index == 4'($past(out_elem_index, 2) + 4'd1)
       && out_frame_addr == $past(out_frame_addr, 2)
       && out_frame_type == $past(out_frame_type, 2)
       && out_data_count == $past(out_data_count, 2)))
    else $error("element sequence broken");

  // a non-final element result never claims to be the empty result
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_elem_valid)
    else $error("non-final result without element");

endmodule

bind addr_header_frame_parser ahfp_checker u_ahfp_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address-header frame parser testbench
// Sends byte streams with valid/stall handshakes. The stream holds
// "ADDR<addr><type><data>LF" frames, broken frames and noise. A scoreboard
// tracks the parser state and predicts every element result. Each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ahfp_pkg::*;

  localparam int DATA_DEPTH = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 2 * DATA_DEPTH + 20;
  localparam int BYTES_PER_PASS = 167;

  typedef struct packed {
    logic [2:0] frame_addr;
    logic [3:0] frame_type;
    logic [4:0] data_count;
    logic [3:0] elem_index;
    logic [4:0] elem_value;
    logic       elem_valid;
    logic       overflowed;
    logic       last;
  } frame_result_t;

  class frame_scoreboard;
    ph_t           phase;
    logic [2:0]    addr;
    logic [3:0]    ftype;
    logic [4:0]    count;
    logic [4:0]    store [DATA_DEPTH];
    logic          ovf;
    frame_result_t element_q[$];
    int            errors;

    function new();
      phase  = PH_HUNT_A;
      addr   = '0;
      ftype  = '0;
      count  = '0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return element_q.size();
    endfunction

    function void queue_element(int idx, logic [4:0] value, logic valid, logic last);
      frame_result_t r;
      r.frame_addr = addr;
      r.frame_type = ftype;
      r.data_count = count;
      r.elem_index = 4'(idx);
      r.elem_value = value;
      r.elem_valid = valid;
      r.overflowed = ovf;
      r.last       = last;
      element_q.push_back(r);
    endfunction

    // Advance the parser by one accepted byte.
    function void note_input(logic [7:0] c);
      int i;
      case (phase)
        PH_WANT_D1: phase = (c == CH_D) ? PH_WANT_D2 : PH_HUNT_A;
        PH_WANT_D2: phase = (c == CH_D) ? PH_WANT_R : PH_HUNT_A;
        PH_WANT_R:  phase = (c == CH_R) ? PH_ADDR : PH_HUNT_A;
        PH_ADDR: begin
          if (c > DIG_LO_EXC && c < ADDR_HI_EXC) begin
            addr  = 3'(c - CH_ZERO);
            phase = PH_TYPE;
          end else begin
            phase = PH_HUNT_A;
          end
        end
        PH_TYPE: begin
          if (c > DIG_LO_EXC && c < TYPE_HI_EXC) begin
            ftype = 4'(c - CH_ZERO);
            count = '0;
            ovf   = 1'b0;
            phase = PH_DATA;
          end else begin
            phase = PH_HUNT_A;
          end
        end
        PH_DATA: begin
          if (c == CH_LF) begin
            phase = PH_HUNT_A;
            if (count == 0) begin
              queue_element(0, 5'd0, 1'b0, 1'b1);
            end else begin
              for (i = 0; i < int'(count); i++)
                queue_element(i, store[i], 1'b1, (i + 1 == int'(count)));
            end
          end else if (c > DIG_LO_EXC && c < DATA_HI_EXC) begin
            // drop characters once the store is full
            if (int'(count) < DATA_DEPTH) begin
              store[count] = 5'(c - CH_ZERO);
              count = count + 5'd1;
            end else begin
              ovf = 1'b1;
            end
          end else begin
            phase = PH_HUNT_A;
          end
        end
        default: phase = (c == CH_A) ? PH_WANT_D1 : PH_HUNT_A;
      endcase
    endfunction

    function void check_field(string name, int got, int want);
      if (got != want)
        report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (element_q.size() == 0) begin
        report("result with no pending element");
        return;
      end
      want = element_q.pop_front();
      check_field("frame_addr", got.frame_addr, want.frame_addr);
      check_field("frame_type", got.frame_type, want.frame_type);
      check_field("data_count", got.data_count, want.data_count);
      check_field("elem_index", got.elem_index, want.elem_index);
      check_field("elem_value", got.elem_value, want.elem_value);
      check_field("elem_valid", got.elem_valid, want.elem_valid);
      check_field("overflowed", got.overflowed, want.overflowed);
      check_field("last", got.last, want.last);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_frame_addr;
  logic [3:0] out_frame_type;
  logic [4:0] out_data_count;
  logic [3:0] out_elem_index;
  logic [4:0] out_elem_value;
  logic       out_elem_valid;
  logic       out_overflowed;
  logic       out_last;

  frame_scoreboard sb;
  logic [7:0]      byte_q[$];
  int              in_idle_pct;
  int              out_idle_pct;
  int              bytes_sent;
  int              quiet_cycles;

  addr_header_frame_parser #(
    .DATA_DEPTH(DATA_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_addr(out_frame_addr),
    .out_frame_type(out_frame_type),
    .out_data_count(out_data_count),
    .out_elem_index(out_elem_index),
    .out_elem_value(out_elem_value),
    .out_elem_valid(out_elem_valid),
    .out_overflowed(out_overflowed),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_frame_addr, out_frame_type, out_data_count, out_elem_index,
                       out_elem_value, out_elem_valid, out_overflowed, out_last});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Hold the byte until the parser takes it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic flush_bytes();
    while (byte_q.size() > 0) send_byte(byte_q.pop_front());
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic add_random_frame();
    int         kind;
    int         len;
    int         cut;
    int         i;
    logic [7:0] fb[$];
    kind = $urandom_range(99);
    if (kind < 15) begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) byte_q.push_back(8'($urandom_range(255)));
      return;
    end
    fb.push_back(CH_A);
    fb.push_back(CH_D);
    fb.push_back(CH_D);
    fb.push_back(CH_R);
    fb.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                           : 8'(CH_ZERO + $urandom_range(4)));
    fb.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                           : 8'(CH_ZERO + $urandom_range(9)));
    // mostly short frames, some full, a few past capacity
    i = $urandom_range(99);
    if (i < 80) len = $urandom_range(0, 6);
    else if (i < 95) len = $urandom_range(7, DATA_DEPTH);
    else len = $urandom_range(DATA_DEPTH + 1, DATA_DEPTH + 4);
    for (i = 0; i < len; i++) fb.push_back(8'(CH_ZERO + $urandom_range(22)));
    fb.push_back(CH_LF);
    if (kind < 30) begin
      // corrupt one byte and cut the frame there
      cut = $urandom_range(1, fb.size() - 1);
      fb[cut] = 8'($urandom_range(255));
      for (i = 0; i <= cut; i++) byte_q.push_back(fb[i]);
    end else begin
      for (i = 0; i < fb.size(); i++) byte_q.push_back(fb[i]);
    end
  endtask

  initial begin
    int pass_idx;
    int mark;
    int frames;
    sb           = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    out_stall    = 1'b0;
    in_idle_pct  = 7;
    out_idle_pct = 66;
    bytes_sent   = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme data digits, empty frame, bad type digit,
    // header mismatch on a repeated A, then a stray line feed.
    push_text("ADDR49");
    byte_q.push_back(CH_ZERO);
    byte_q.push_back(8'd70);
    byte_q.push_back(CH_LF);
    push_text("ADDR00");
    byte_q.push_back(CH_LF);
    push_text("ADDR3:");
    push_text("AADDR");
    byte_q.push_back(CH_LF);
    byte_q.push_back(8'hFF);
    flush_bytes();

    for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
      case (pass_idx)
        0: begin
          in_idle_pct  = 7;
          out_idle_pct = 66;
        end
        1: begin
          in_idle_pct  = 66;
          out_idle_pct = 7;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      mark   = bytes_sent;
      frames = 0;
      while (bytes_sent - mark < BYTES_PER_PASS) begin
        add_random_frame();
        flush_bytes();
        frames++;
        if (frames == 6) wait_drained();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("elements still pending at end of run");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ahfp_pkg.sv
hdl/ahfp_front.sv
hdl/ahfp_queue.sv
hdl/ahfp_back.sv
hdl/addr_header_frame_parser.sv
hdl/ahfp_checker.sv
verif/testbench.sv
